// File: rtl/balance_robot_cascade_controller_assert.svh
// Assertion macros for the balance controller checker.
// Used only by the checker file; needs nothing else.
`ifndef BALANCE_ROBOT_CASCADE_CONTROLLER_ASSERT_SVH
`define BALANCE_ROBOT_CASCADE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, masked while reset is asserted.
`define BRCC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("balance controller assertion failed");

// Next-cycle implication, masked while reset is asserted.
`define BRCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("balance controller assertion failed");

`endif

// File: rtl/brcc_pkg.sv
// Shared types, codes and saturation helpers for the balance controller.
// No dependencies; imported by brcc_fmul, the top level and the checker.
package brcc_pkg;

    localparam int WORD_W = 32;
    localparam int ACC_W  = 36;

    typedef enum logic [0:0] {
        OP_TICK = 1'b0,
        OP_CMD  = 1'b1
    } t_op;

    localparam logic [2:0] REG_PROP_GAIN = 3'd0;
    localparam logic [2:0] REG_INT_GAIN  = 3'd1;
    localparam logic [2:0] REG_RATE_GAIN = 3'd2;
    localparam logic [2:0] REG_INT_LIMIT = 3'd3;
    localparam logic [2:0] REG_CROUCH    = 3'd4;
    localparam logic [2:0] REG_JUMP_END  = 3'd5;

    typedef enum logic [4:0] {
        S_IDLE,
        S_FLT_A, S_FLT_B, S_FLT_C,
        S_VEL_A, S_VEL_B, S_VEL_C, S_VEL_D, S_VEL_E,
        S_PIT_A, S_PIT_B, S_PIT_C,
        S_PID_A, S_PID_B, S_PID_C,
        S_OUT_A, S_OUT_B, S_OUT_C,
        S_LEG_A, S_LEG_B, S_LEG_C, S_LEG_D, S_LEG_E, S_LEG_F,
        S_DONE
    } t_state;

    function automatic logic signed [WORD_W-1:0] f_sat32(input logic signed [ACC_W-1:0] v);
        if (v > $signed(ACC_W'(32'h7FFF_FFFF))) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -$signed(ACC_W'(33'h0_8000_0000))) begin
            return 32'sh8000_0000;
        end
        return v[WORD_W-1:0];
    endfunction

    function automatic logic signed [WORD_W-1:0] f_clamp(input logic signed [WORD_W-1:0] v,
                                                       input logic signed [WORD_W-1:0] lo,
                                                       input logic signed [WORD_W-1:0] hi);
        if (v > hi) begin
            return hi;
        end else if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

endpackage

// File: rtl/brcc_if.sv
// Valid/ready channel interfaces for the balance controller items and results.
// Depends on nothing.
interface brcc_in_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic signed [31:0] measured_fwd_speed;
    logic signed [31:0] measured_pitch;
    logic signed [31:0] measured_pitch_rate;
    logic signed [31:0] cmd_forward;
    logic signed [31:0] cmd_jump;
    logic signed [31:0] cmd_height;
    logic signed [31:0] cmd_roll;
    logic signed [31:0] cmd_turn;

    modport source (output valid, operation, measured_fwd_speed, measured_pitch,
                    measured_pitch_rate, cmd_forward, cmd_jump, cmd_height, cmd_roll,
                    cmd_turn, input ready);
    modport sink (input valid, operation, measured_fwd_speed, measured_pitch,
                  measured_pitch_rate, cmd_forward, cmd_jump, cmd_height, cmd_roll,
                  cmd_turn, output ready);
endinterface

interface brcc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] left_wheel_speed;
    logic signed [31:0] right_wheel_speed;
    logic signed [31:0] hip_right_pos;
    logic signed [31:0] hip_left_pos;
    logic signed [31:0] knee_right_pos;
    logic signed [31:0] knee_left_pos;
    logic               jump_active;

    modport source (output valid, left_wheel_speed, right_wheel_speed, hip_right_pos,
                    hip_left_pos, knee_right_pos, knee_left_pos, jump_active, input ready);
    modport sink (input valid, left_wheel_speed, right_wheel_speed, hip_right_pos,
                  hip_left_pos, knee_right_pos, knee_left_pos, jump_active, output ready);
endinterface

// File: rtl/brcc_fmul.sv
// Shared fixed-point multiplier: registered 32x32 product, floor shift, saturation.
// Depends on brcc_pkg.
module brcc_fmul import brcc_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic signed [WORD_W-1:0] i_a,
    input  logic signed [WORD_W-1:0] i_b,
    output logic signed [WORD_W-1:0] o_y
);

    logic signed [2*WORD_W-1:0] r_prod;
    logic signed [2*WORD_W-1:0] w_sh;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    // Arithmetic shift right rounds toward minus infinity.
    assign w_sh = r_prod >>> FRAC_BITS;

    always_comb begin
        if (w_sh > 64'sd2147483647) begin
            o_y = 32'sh7FFF_FFFF;
        end else if (w_sh < -64'sd2147483648) begin
            o_y = 32'sh8000_0000;
        end else begin
            o_y = w_sh[WORD_W-1:0];
        end
    end

endmodule

// File: rtl/balance_robot_cascade_controller.sv
// Top level of the cascaded balance controller for a wheel-legged robot.
// Depends on brcc_pkg, brcc_if (channel interfaces) and brcc_fmul.
//
// Usage. Items arrive on i_in, a valid/ready channel; a transfer takes place
// at a rising edge with valid and ready both high. A command item (operation
// set) updates the speed, turn, height and roll targets, or starts a jump,
// within the cycle of its transfer and gives no result; the block stays ready.
// A control tick item runs the whole cascade through one shared multiplier
// under a step sequencer, and i_in stays low on ready from the transfer
// until the sequencer is back in its idle step, so no further item is
// taken while a tick is in progress. The sequence of seventeen dependent
// products through the single multiplier sets how long a tick takes.
// The result sits in an output register; a new item is taken while it waits.
// If a further tick finishes while the receiver still stalls, the sequencer
// holds in its final step until the earlier transfer has gone.
// Gains, the integrator limit and the jump timing are written over the APB
// port at byte address 4*index; a write takes a setup and an access cycle
// and pready is tied high. Reset (synchronous, active low) restores the
// default gains, limit and jump timing, clears the filter, the other targets,
// the integrators and the jump sequencer and sets the height to one half.
module balance_robot_cascade_controller import brcc_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    brcc_in_if.sink           i_in,
    brcc_out_if.source        o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // Fixed-point constants, rounded to nearest at elaboration.
    localparam logic signed [31:0] K_ONE  = 32'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [31:0] K_HALF = 32'(((64'sd1 <<< FRAC_BITS) + 64'sd1) / 64'sd2);
    localparam logic signed [31:0] K_95   = 32'(((64'sd95 <<< FRAC_BITS) + 64'sd50) / 64'sd100);
    localparam logic signed [31:0] K_05   = 32'(((64'sd5 <<< FRAC_BITS) + 64'sd50) / 64'sd100);
    localparam logic signed [31:0] K_005  =
        32'(((64'sd5 <<< FRAC_BITS) + 64'sd500) / 64'sd1000);
    localparam logic signed [31:0] K_02   = 32'(((64'sd2 <<< FRAC_BITS) + 64'sd5) / 64'sd10);
    localparam logic signed [31:0] K_04   = 32'(((64'sd4 <<< FRAC_BITS) + 64'sd50) / 64'sd100);
    localparam logic signed [31:0] K_01   = 32'(((64'sd1 <<< FRAC_BITS) + 64'sd5) / 64'sd10);
    localparam logic signed [31:0] K_009  =
        32'(((64'sd9 <<< FRAC_BITS) + 64'sd500) / 64'sd1000);
    localparam logic signed [31:0] K_100  = 32'(64'sd100 <<< FRAC_BITS);
    localparam logic signed [31:0] K_015  =
        32'(((64'sd15 <<< FRAC_BITS) + 64'sd50) / 64'sd100);
    localparam logic signed [31:0] K_09   = 32'(((64'sd9 <<< FRAC_BITS) + 64'sd5) / 64'sd10);
    localparam logic signed [31:0] K_06   = 32'(((64'sd6 <<< FRAC_BITS) + 64'sd5) / 64'sd10);
    localparam logic signed [31:0] K_105  =
        32'(((64'sd105 <<< FRAC_BITS) + 64'sd50) / 64'sd100);
    localparam logic signed [31:0] K_03   = 32'(((64'sd3 <<< FRAC_BITS) + 64'sd5) / 64'sd10);
    localparam logic signed [31:0] K_4    = 32'(64'sd4 <<< FRAC_BITS);

    // Configuration registers.
    logic [26:0] r_ppg, r_pig, r_prg;
    logic [21:0] r_lim;
    logic [15:0] r_crouch, r_jend;

    // Persistent controller state.
    logic signed [31:0] r_sst, r_si, r_pi;
    logic signed [31:0] r_fwd, r_turn, r_ht, r_roll, r_hbj;
    logic               r_jumping;
    logic [15:0]        r_cnt;

    // Working registers of one tick.
    logic signed [31:0] r_speed, r_pitch, r_rate;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [31:0] r_verr, r_des, r_perr, r_kp, r_dv, r_hv;
    logic signed [31:0] r_left, r_right, r_dr, r_dl, r_hr, r_hl, r_kr, r_kl;

    // Output register.
    logic               r_ovalid;
    logic signed [31:0] r_o_left, r_o_right, r_o_hr, r_o_hl, r_o_kr, r_o_kl;
    logic               r_o_jump;

    t_state r_state, n_state;

    logic               w_in_acc, w_out_acc, w_cfg_wr, w_load;
    logic [2:0]         w_idx;
    logic signed [31:0] w_a, w_b, w_m;
    logic signed [31:0] w_apitch, w_lim, w_jmp_ht, w_offr;
    logic [15:0]        w_cnt_inc;

    assign w_in_acc  = i_in.valid && i_in.ready;
    assign w_out_acc = o_out.valid && o_out.ready;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_idx     = paddr[4:2];
    assign pready    = 1'b1;
    assign i_in.ready = (r_state == S_IDLE);
    assign w_load    = (r_state == S_DONE) && (!r_ovalid || o_out.ready);

    assign w_lim = $signed({10'b0, r_lim});
    assign w_apitch = (r_pitch[31] == 1'b0) ? r_pitch :
                      (r_pitch == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -r_pitch;
    assign w_offr = f_sat32(-ACC_W'(w_m));
    assign w_cnt_inc = (r_cnt != 16'hFFFF) ? r_cnt + 16'd1 : r_cnt;

    // Height target during the jump: crouched, extended, then restored.
    always_comb begin
        w_jmp_ht = K_015;
        if (w_cnt_inc > r_crouch) begin
            w_jmp_ht = K_09;
        end
        if (w_cnt_inc > r_jend) begin
            w_jmp_ht = r_hbj;
        end
    end

    // Register read-back.
    always_comb begin
        prdata = '0;
        unique case (w_idx)
            REG_PROP_GAIN: prdata = {5'b0, r_ppg};
            REG_INT_GAIN:  prdata = {5'b0, r_pig};
            REG_RATE_GAIN: prdata = {5'b0, r_prg};
            REG_INT_LIMIT: prdata = {10'b0, r_lim};
            REG_CROUCH:    prdata = {16'b0, r_crouch};
            REG_JUMP_END:  prdata = {16'b0, r_jend};
            default:       prdata = '0;
        endcase
    end

    // Sequencer: each step issues at most one product, which the next step consumes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_a     = '0;
        w_b     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_in.operation == OP_TICK)) begin
                    n_state = S_FLT_A;
                end
            end
            S_DONE: begin
                if (!r_ovalid || o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = t_state'(r_state + 5'd1);
        endcase
        unique case (r_state)
            S_FLT_A: begin w_a = K_95;   w_b = r_sst;  end
            S_FLT_B: begin w_a = K_05;   w_b = r_fwd;  end
            S_VEL_A: begin w_a = K_04;   w_b = r_sst;  end
            S_VEL_B: begin w_a = K_005;  w_b = r_verr; end
            S_VEL_D: begin w_a = K_01;   w_b = r_si;   end
            S_PIT_A: begin w_a = K_100;  w_b = w_apitch; end
            S_PIT_B: begin w_a = K_009;  w_b = r_perr; end
            S_PIT_C: begin w_a = r_kp;   w_b = r_perr; end
            S_PID_A: begin w_a = $signed({5'b0, r_pig}); w_b = r_pi; end
            S_PID_B: begin w_a = $signed({5'b0, r_prg}); w_b = r_rate; end
            S_OUT_A: begin w_a = K_HALF; w_b = r_dv;   end
            S_OUT_B: begin w_a = K_4;    w_b = r_turn; end
            S_OUT_C: begin w_a = K_HALF; w_b = r_roll; end
            S_LEG_B: begin w_a = -K_06;  w_b = r_dr;   end
            S_LEG_C: begin w_a = -K_06;  w_b = r_dl;   end
            S_LEG_D: begin w_a = K_105;  w_b = r_dr;   end
            S_LEG_E: begin w_a = K_105;  w_b = r_dl;   end
            default: begin w_a = '0;     w_b = '0;     end
        endcase
    end

    brcc_fmul #(.FRAC_BITS(FRAC_BITS)) u_fmul (
        .i_clk (i_clk),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_y   (w_m)
    );

    // Configuration, targets, filter, integrators and jump sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppg     <= 27'd16384000;
            r_pig     <= 27'd4587520;
            r_prg     <= 27'd655360;
            r_lim     <= 22'd655360;
            r_crouch  <= 16'd1200;
            r_jend    <= 16'd1260;
            r_sst     <= '0;
            r_si      <= '0;
            r_pi      <= '0;
            r_fwd     <= '0;
            r_turn    <= '0;
            r_ht      <= K_HALF;
            r_roll    <= '0;
            r_hbj     <= K_HALF;
            r_jumping <= 1'b0;
            r_cnt     <= '0;
        end else begin
            if (w_cfg_wr) begin
                unique case (w_idx)
                    REG_PROP_GAIN: r_ppg    <= pwdata[26:0];
                    REG_INT_GAIN:  r_pig    <= pwdata[26:0];
                    REG_RATE_GAIN: r_prg    <= pwdata[26:0];
                    REG_INT_LIMIT: r_lim    <= pwdata[21:0];
                    REG_CROUCH:    r_crouch <= pwdata[15:0];
                    REG_JUMP_END:  r_jend   <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (w_in_acc && (i_in.operation == OP_CMD)) begin
                if ((i_in.cmd_jump > K_ONE) && !r_jumping) begin
                    // Jump start: only the roll target changes.
                    r_jumping <= 1'b1;
                    r_cnt     <= '0;
                    r_hbj     <= r_ht;
                    r_roll    <= '0;
                end else begin
                    r_fwd  <= f_clamp(i_in.cmd_forward, -K_03, K_03);
                    r_ht   <= f_clamp(f_sat32(ACC_W'(i_in.cmd_height) + ACC_W'(K_HALF)),
                                      '0, K_ONE);
                    r_roll <= f_clamp(i_in.cmd_roll, -K_06, K_06);
                    r_turn <= f_clamp(i_in.cmd_turn, -K_03, K_03);
                end
            end
            unique case (r_state)
                S_FLT_C: r_sst <= f_sat32(r_acc + ACC_W'(w_m));
                S_VEL_C: r_si <= f_clamp(f_sat32(ACC_W'(r_si) + ACC_W'(w_m)), -K_02, K_02);
                S_PIT_C: r_pi <= f_clamp(f_sat32(ACC_W'(r_pi) + ACC_W'(w_m)), -w_lim, w_lim);
                S_OUT_C: begin
                    if (r_jumping) begin
                        r_ht <= w_jmp_ht;
                        if (w_cnt_inc > r_jend) begin
                            r_cnt     <= '0;
                            r_jumping <= 1'b0;
                        end else begin
                            r_cnt <= w_cnt_inc;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Working registers of the tick in progress.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_speed <= i_in.measured_fwd_speed;
            r_pitch <= i_in.measured_pitch;
            r_rate  <= i_in.measured_pitch_rate;
        end
        unique case (r_state)
            S_FLT_B: r_acc <= ACC_W'(w_m);
            S_VEL_A: r_verr <= f_sat32(ACC_W'(r_speed) - ACC_W'(r_sst));
            S_VEL_B: r_acc <= ACC_W'(w_m);
            S_VEL_C: r_acc <= r_acc - ACC_W'(r_verr);
            S_VEL_E: r_des <= f_sat32(r_acc - ACC_W'(w_m));
            S_PIT_A: r_perr <= f_sat32(ACC_W'(r_pitch) - ACC_W'(r_des));
            S_PIT_B: r_kp <= f_sat32($signed({9'b0, r_ppg}) + ACC_W'(w_m));
            S_PID_A: r_acc <= ACC_W'(w_m);
            S_PID_B: r_acc <= r_acc + ACC_W'(w_m);
            S_PID_C: r_dv <= f_sat32(r_acc + ACC_W'(w_m));
            S_OUT_B: r_hv <= w_m;
            S_OUT_C: begin
                r_right <= f_sat32(ACC_W'(r_hv) + ACC_W'(w_m));
                r_left  <= f_sat32(ACC_W'(r_hv) - ACC_W'(w_m));
            end
            S_LEG_A: begin
                // The height target here already carries this tick's jump step.
                r_dr <= f_sat32(ACC_W'(r_ht) + ACC_W'(w_offr) - ACC_W'(K_HALF));
                r_dl <= f_sat32(ACC_W'(r_ht) + ACC_W'(w_m) - ACC_W'(K_HALF));
            end
            S_LEG_C: r_hr <= w_m;
            S_LEG_D: r_hl <= w_m;
            S_LEG_E: r_kr <= w_m;
            S_LEG_F: r_kl <= w_m;
            default: ;
        endcase
    end

    // Output register, separate from the working set so a stalled result survives.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (w_out_acc) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_left  <= r_left;
            r_o_right <= r_right;
            r_o_hr    <= r_hr;
            r_o_hl    <= r_hl;
            r_o_kr    <= r_kr;
            r_o_kl    <= r_kl;
            r_o_jump  <= r_jumping;
        end
    end

    assign o_out.valid             = r_ovalid;
    assign o_out.left_wheel_speed  = r_o_left;
    assign o_out.right_wheel_speed = r_o_right;
    assign o_out.hip_right_pos     = r_o_hr;
    assign o_out.hip_left_pos      = r_o_hl;
    assign o_out.knee_right_pos    = r_o_kr;
    assign o_out.knee_left_pos     = r_o_kl;
    assign o_out.jump_active       = r_o_jump;

endmodule

// File: rtl/brcc_checker.sv
// Port-level checker for the balance controller, bound to the top level.
// Depends on brcc_pkg and balance_robot_cascade_controller_assert.svh.
`include "balance_robot_cascade_controller_assert.svh"
module brcc_checker import brcc_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_in_op,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_psel,
    input logic i_pready
);

    `BRCC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `BRCC_ASSERT_NEXT(a_tick_busy, i_clk, i_rst_n,
        i_in_valid && i_in_ready && (i_in_op == OP_TICK), !i_in_ready)
    `BRCC_ASSERT_NEXT(a_cmd_ready, i_clk, i_rst_n,
        i_in_valid && i_in_ready && (i_in_op == OP_CMD), i_in_ready)
    `BRCC_ASSERT_NOW(a_pready, i_clk, i_rst_n, i_psel, i_pready)

endmodule

bind balance_robot_cascade_controller brcc_checker u_brcc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_op     (i_in.operation),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_psel      (psel),
    .i_pready    (pready)
);
